// ===== hdl/mwlc_pkg.sv =====
// Shared types and constants of the multichannel window / color table compositor.
// Used by the lane, the merge stage and the top level; depends on nothing else.
`timescale 1ns / 1ps

package mwlc_pkg;

    // Field widths of the stream words
    localparam int CMD_W       = 2;
    localparam int CH_W        = 2;
    localparam int LEVEL_W     = 8;
    localparam int COLOR_W     = 24;
    localparam int SAMPLE_W    = 32;
    localparam int ENABLE_W    = 4;
    localparam int PIXEL_W     = 32;
    localparam int LEVELS      = 256;
    localparam int SAMPLE_FIELDS = 4;

    // Bit positions of the fields inside the input tdata
    localparam int CH_LSB      = 0;
    localparam int INDEX_LSB   = CH_LSB + CH_W;
    localparam int ENTRY_LSB   = INDEX_LSB + LEVEL_W;
    localparam int LOW_LSB     = ENTRY_LSB + COLOR_W;
    localparam int SCALE_LSB   = LOW_LSB + SAMPLE_W;
    localparam int SAMPLE_LSB  = SCALE_LSB + SAMPLE_W;
    localparam int TDATA_USED  = SAMPLE_LSB + SAMPLE_FIELDS * SAMPLE_W;
    localparam int TDATA_W     = ((TDATA_USED + 7) / 8) * 8;

    // Command codes carried in tuser
    localparam logic [CMD_W-1:0] CMD_PIXEL  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TABLE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WINDOW = 2'd2;

    localparam logic [SAMPLE_W-1:0] DEFAULT_SCALE = 32'd16711680;
    localparam logic [7:0]          OPAQUE_ALPHA  = 8'hFF;
    localparam logic [PIXEL_W-1:0]  EMPTY_PIXEL   = 32'hFF0A0909;

    // Per-lane strobes driven by the top-level pipeline control
    typedef struct packed {
        logic win_we;   // window write for this lane at input acceptance
        logic load1;    // word enters the difference stage
        logic load2;    // word enters the level stage
        logic tab_we;   // table write for this lane leaves the level stage
        logic rd_en;    // pixel leaves the level stage, table is read
    } lane_ctrl_t;

endpackage

// ===== hdl/mwlc_lane.sv =====
// One channel lane: window registers, difference, multiply to a grey level,
// and the channel's 256-entry color table. Depends on mwlc_pkg.
`timescale 1ns / 1ps

module mwlc_lane (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mwlc_pkg::lane_ctrl_t            ctrl,
    input  logic [mwlc_pkg::SAMPLE_W-1:0]   sample,
    input  logic [mwlc_pkg::SAMPLE_W-1:0]   window_low,
    input  logic [mwlc_pkg::SAMPLE_W-1:0]   window_scale,
    input  logic [mwlc_pkg::LEVEL_W-1:0]    table_index,
    input  logic [mwlc_pkg::COLOR_W-1:0]    table_entry,
    output logic [mwlc_pkg::COLOR_W-1:0]    color
);
    import mwlc_pkg::*;

    logic [SAMPLE_W-1:0]   low_reg;
    logic [SAMPLE_W-1:0]   scale_reg;
    logic [SAMPLE_W:0]     diff;
    logic [SAMPLE_W-1:0]   d_next;
    logic [SAMPLE_W-1:0]   d_reg;
    logic [SAMPLE_W-1:0]   scale_pipe_reg;
    logic [2*SAMPLE_W-1:0] product;
    logic [LEVEL_W-1:0]    level_next;
    logic [LEVEL_W-1:0]    level_reg;
    logic [COLOR_W-1:0]    color_reg;
    logic [COLOR_W-1:0]    table_mem [LEVELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg   <= '0;
            scale_reg <= DEFAULT_SCALE;
        end
        else if (ctrl.win_we)
        begin
            low_reg   <= window_low;
            scale_reg <= window_scale;
        end
    end

    // The signed difference needs 33 bits; a non-positive one gives level zero.
    assign diff   = {sample[SAMPLE_W-1], sample} - {low_reg[SAMPLE_W-1], low_reg};
    assign d_next = diff[SAMPLE_W] ? '0 : diff[SAMPLE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ctrl.load1)
        begin
            d_reg          <= d_next;
            scale_pipe_reg <= scale_reg;
        end
    end

    // Integer part of the Q32.32 product, saturated at level 255.
    assign product    = d_reg * scale_pipe_reg;
    assign level_next = (|product[2*SAMPLE_W-1:SAMPLE_W+LEVEL_W]) ? '1
                        : product[SAMPLE_W+LEVEL_W-1:SAMPLE_W];

    always_ff @(posedge clk)
    begin
        if (ctrl.load2)
        begin
            level_reg <= level_next;
        end
    end

    // Table writes travel the pipeline so they stay in order with pixel reads.
    always_ff @(posedge clk)
    begin
        if (ctrl.tab_we)
        begin
            table_mem[table_index] <= table_entry;
        end
        if (ctrl.rd_en)
        begin
            color_reg <= table_mem[level_reg];
        end
    end

    assign color = color_reg;

endmodule

// ===== hdl/mwlc_merge.sv =====
// Merge stage: adds the colors of the enabled lanes per component, saturates
// and registers the opaque output pixel. Depends on mwlc_pkg.
`timescale 1ns / 1ps

module mwlc_merge #(
    parameter int LANES = 4
) (
    input  logic                                    clk,
    input  logic                                    load,
    input  logic [LANES-1:0]                        lane_en,
    input  logic [LANES-1:0][mwlc_pkg::COLOR_W-1:0] colors,
    output logic [mwlc_pkg::PIXEL_W-1:0]            pixel
);
    import mwlc_pkg::*;

    localparam int SUM_W = 9 + $clog2(LANES);

    logic [SUM_W-1:0]   red_sum;
    logic [SUM_W-1:0]   green_sum;
    logic [SUM_W-1:0]   blue_sum;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [PIXEL_W-1:0] pixel_next;
    logic [PIXEL_W-1:0] pixel_reg;

    always_comb
    begin
        red_sum   = '0;
        green_sum = '0;
        blue_sum  = '0;
        for (int i = 0; i < LANES; i++)
        begin
            if (lane_en[i])
            begin
                red_sum   = red_sum   + SUM_W'(colors[i][23:16]);
                green_sum = green_sum + SUM_W'(colors[i][15:8]);
                blue_sum  = blue_sum  + SUM_W'(colors[i][7:0]);
            end
        end
    end

    assign red   = (|red_sum[SUM_W-1:8])   ? 8'hFF : red_sum[7:0];
    assign green = (|green_sum[SUM_W-1:8]) ? 8'hFF : green_sum[7:0];
    assign blue  = (|blue_sum[SUM_W-1:8])  ? 8'hFF : blue_sum[7:0];

    assign pixel_next = (|lane_en) ? {OPAQUE_ALPHA, red, green, blue} : EMPTY_PIXEL;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign pixel = pixel_reg;

endmodule

// ===== hdl/multichannel_window_lut_compositor_unit.sv =====
// Top level of the multichannel window / color table compositor.
// Depends on mwlc_pkg, mwlc_lane and mwlc_merge.
`timescale 1ns / 1ps

// Usage
// The slave stream carries one word per pixel or command; tuser holds the
// command (pixel, color table write, window write). Pixel words carry one
// signed Q16.16 sample per channel; each enabled channel maps its sample to a
// grey level, looks up a tinted color and the lanes' colors are summed into
// one opaque RGB pixel on the master stream. Command words produce no output.
// cfg_we/cfg_wdata load the channel enable mask; write it only while idle.
// A pixel passes the difference, multiply, table read and merge registers in
// that order before it reaches m_tvalid. Throughput is one word per clock:
// each stage has its own valid bit and every lane has its own multiplier and
// table port, so a new word is taken every cycle the pipeline is not full.
// When m_tready is low the output word holds and the stages behind it keep
// filling bubbles; s_tready drops only once every stage is occupied.
// Reset clears the enable mask, the pipeline valids and the windows (low 0,
// scale 255.0); color tables are undefined until written.
module multichannel_window_lut_compositor_unit #(
    parameter int CHANNELS = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // channel, table_index, table_entry, window_low, window_scale,
    // sample_0, sample_1, sample_2, sample_3 (from bit 0 up), zero padded
    input  logic [mwlc_pkg::TDATA_W-1:0]         s_tdata,
    // command
    input  logic [mwlc_pkg::CMD_W-1:0]           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // pixel
    output logic [mwlc_pkg::PIXEL_W-1:0]         m_tdata,
    input  logic                                 cfg_we,
    input  logic [mwlc_pkg::ENABLE_W-1:0]        cfg_wdata
);
    import mwlc_pkg::*;

    localparam int LANES = (CHANNELS < SAMPLE_FIELDS) ? CHANNELS : SAMPLE_FIELDS;

    logic [ENABLE_W-1:0] enable_reg;
    logic [LANES-1:0]    lane_en;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic pix1_reg, pix2_reg;
    logic [CH_W-1:0]    ch1_reg, ch2_reg;
    logic [LEVEL_W-1:0] idx1_reg, idx2_reg;
    logic [COLOR_W-1:0] entry1_reg, entry2_reg;

    logic accept, keep, is_pixel;
    logic ready1, ready2, ready3, ready4;
    logic adv1, adv2, adv3;

    logic [CMD_W-1:0]   command;
    logic [CH_W-1:0]    channel;
    logic [LEVEL_W-1:0] table_index;
    logic [COLOR_W-1:0] table_entry;
    logic [SAMPLE_W-1:0] window_low;
    logic [SAMPLE_W-1:0] window_scale;
    logic [SAMPLE_FIELDS-1:0][SAMPLE_W-1:0] sample;

    logic [LANES-1:0][COLOR_W-1:0] colors;

    assign command      = s_tuser;
    assign channel      = s_tdata[CH_LSB +: CH_W];
    assign table_index  = s_tdata[INDEX_LSB +: LEVEL_W];
    assign table_entry  = s_tdata[ENTRY_LSB +: COLOR_W];
    assign window_low   = s_tdata[LOW_LSB +: SAMPLE_W];
    assign window_scale = s_tdata[SCALE_LSB +: SAMPLE_W];

    always_comb
    begin
        for (int k = 0; k < SAMPLE_FIELDS; k++)
        begin
            sample[k] = s_tdata[SAMPLE_LSB + k*SAMPLE_W +: SAMPLE_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= '0;
        end
        else if (cfg_we)
        begin
            enable_reg <= cfg_wdata;
        end
    end

    assign lane_en = enable_reg[LANES-1:0];

    // Ready chain: table writes leave after the level stage, pixels go on.
    assign ready4 = !v4_reg || m_tready;
    assign adv3   = v3_reg && ready4;
    assign ready3 = !v3_reg || ready4;
    assign adv2   = v2_reg && (!pix2_reg || ready3);
    assign ready2 = !v2_reg || !pix2_reg || ready3;
    assign adv1   = v1_reg && ready2;
    assign ready1 = !v1_reg || ready2;

    assign s_tready = ready1;
    assign accept   = s_tvalid && ready1;
    assign is_pixel = (command == CMD_PIXEL);
    // Window writes finish at acceptance; the unused code is dropped there too.
    assign keep     = is_pixel || (command == CMD_TABLE);

    assign v1_next = (v1_reg && !adv1) || (accept && keep);
    assign v2_next = (v2_reg && !adv2) || adv1;
    assign v3_next = (v3_reg && !adv3) || (adv2 && pix2_reg);
    assign v4_next = (v4_reg && !m_tready) || adv3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix1_reg   <= is_pixel;
            ch1_reg    <= channel;
            idx1_reg   <= table_index;
            entry1_reg <= table_entry;
        end
        if (adv1)
        begin
            pix2_reg   <= pix1_reg;
            ch2_reg    <= ch1_reg;
            idx2_reg   <= idx1_reg;
            entry2_reg <= entry1_reg;
        end
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        lane_ctrl_t lane_ctrl;

        always_comb
        begin
            lane_ctrl.win_we = accept && (command == CMD_WINDOW)
                               && (channel == CH_W'(i));
            lane_ctrl.load1  = accept && keep;
            lane_ctrl.load2  = adv1;
            lane_ctrl.tab_we = adv2 && !pix2_reg && (ch2_reg == CH_W'(i));
            lane_ctrl.rd_en  = adv2 && pix2_reg;
        end

        mwlc_lane u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (lane_ctrl),
            .sample       (sample[i]),
            .window_low   (window_low),
            .window_scale (window_scale),
            .table_index  (idx2_reg),
            .table_entry  (entry2_reg),
            .color        (colors[i])
        );
    end

    mwlc_merge #(
        .LANES (LANES)
    ) u_merge (
        .clk     (clk),
        .load    (adv3),
        .lane_en (lane_en),
        .colors  (colors),
        .pixel   (m_tdata)
    );

    assign m_tvalid = v4_reg;

    // A pixel leaving the read stage always lands in the output register.
    a_merge_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        adv3 |=> m_tvalid)
        else $error("merged pixel did not reach the output");

    // Every emitted pixel is opaque.
    a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        $past(adv3) |-> (m_tdata[PIXEL_W-1:PIXEL_W-8] == OPAQUE_ALPHA))
        else $error("output pixel is not opaque");

    // With no lane enabled at merge time the fixed empty pixel is produced.
    a_empty_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(adv3) && ($past(lane_en) == '0)) |-> (m_tdata == EMPTY_PIXEL))
        else $error("empty pixel expected with no lane enabled");

    // A stalled output word must keep the read stage from advancing into it.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && !m_tready) |-> !adv3)
        else $error("read stage advanced into a stalled output");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for multichannel_window_lut_compositor_unit: directed and random stream words,
// an in-bench composite predictor and a scoreboard of expected pixels.
// Depends on mwlc_pkg and the compositor RTL only.

module testbench;
    import mwlc_pkg::*;

    localparam int NUM_CH       = 4;
    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_WORDS  = 240;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]                         cmd;
        logic [CH_W-1:0]                          ch;
        logic [LEVEL_W-1:0]                       index;
        logic [COLOR_W-1:0]                       entry;
        logic [SAMPLE_W-1:0]                      low;
        logic [SAMPLE_W-1:0]                      scale;
        logic [SAMPLE_FIELDS-1:0][SAMPLE_W-1:0]   samples;
    } stream_word_t;

    typedef enum int {READY_ALWAYS, READY_LIGHT, READY_HEAVY, READY_PERIODIC} ready_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // channel, table_index, table_entry, window_low, window_scale,
    // sample_0, sample_1, sample_2, sample_3 (from bit 0 up), zero padded
    logic [TDATA_W-1:0]    s_tdata = '0;
    // command
    logic [CMD_W-1:0]      s_tuser = CMD_PIXEL;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // pixel
    logic [PIXEL_W-1:0]    m_tdata;
    logic                  cfg_we = 1'b0;
    logic [ENABLE_W-1:0]   cfg_wdata = '0;

    // Predictor state, advanced as words are accepted
    logic [COLOR_W-1:0]    lut_model [NUM_CH*LEVELS];
    logic [SAMPLE_W-1:0]   low_model [NUM_CH];
    logic [SAMPLE_W-1:0]   scale_model [NUM_CH];
    logic [ENABLE_W-1:0]   enable_model;

    // Generator shadow, advanced as words are queued
    logic [SAMPLE_W-1:0]   gen_low [NUM_CH];
    logic [SAMPLE_W-1:0]   gen_scale [NUM_CH];
    logic [SAMPLE_W-1:0]   gen_width [NUM_CH];
    bit                    gen_written [NUM_CH*LEVELS];
    logic [ENABLE_W-1:0]   gen_enable;

    stream_word_t          pending_words [$];
    logic [PIXEL_W-1:0]    expected_pixels [$];
    stream_word_t          current_word;
    logic [PIXEL_W-1:0]    wanted_pixel;
    int                    burst_left = 0;
    int                    gap_left = 0;
    ready_mode_t           ready_mode = READY_ALWAYS;
    int                    ready_left = 0;
    int                    cycle_count = 0;
    int                    mismatch_count = 0;
    int                    queued_words = 0;

    multichannel_window_lut_compositor_unit #(
        .CHANNELS (NUM_CH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // The difference is taken in 33 bits so that it never wraps.
    function automatic logic [LEVEL_W-1:0] window_level(logic [SAMPLE_W-1:0] sample,
                                                        logic [SAMPLE_W-1:0] low,
                                                        logic [SAMPLE_W-1:0] scale);
        logic signed [SAMPLE_W:0] diff;
        logic [63:0]              product;
        diff = $signed({sample[SAMPLE_W-1], sample}) - $signed({low[SAMPLE_W-1], low});
        if (diff <= 0)
            return '0;
        product = {32'd0, diff[SAMPLE_W-1:0]} * {32'd0, scale};
        if (product[63:32] > 32'd255)
            return 8'd255;
        return product[39:32];
    endfunction

    function automatic logic [PIXEL_W-1:0] composite_pixel(stream_word_t w);
        logic [9:0]          red;
        logic [9:0]          green;
        logic [9:0]          blue;
        logic [LEVEL_W-1:0]  level;
        logic [COLOR_W-1:0]  tint;
        int                  c;
        if (enable_model == '0)
            return EMPTY_PIXEL;
        red = '0;
        green = '0;
        blue = '0;
        for (c = 0; c < NUM_CH; c++)
        begin
            if (enable_model[c])
            begin
                level = window_level(w.samples[c], low_model[c], scale_model[c]);
                tint = lut_model[c*LEVELS + int'(level)];
                red = red + {2'b00, tint[23:16]};
                green = green + {2'b00, tint[15:8]};
                blue = blue + {2'b00, tint[7:0]};
            end
        end
        if (red > 10'd255)
            red = 10'd255;
        if (green > 10'd255)
            green = 10'd255;
        if (blue > 10'd255)
            blue = 10'd255;
        return {OPAQUE_ALPHA, red[7:0], green[7:0], blue[7:0]};
    endfunction

    task automatic apply_word(stream_word_t w);
        case (w.cmd)
            CMD_PIXEL:  expected_pixels.insert(expected_pixels.size(), composite_pixel(w));
            CMD_TABLE:  lut_model[int'(w.ch)*LEVELS + int'(w.index)] = w.entry;
            CMD_WINDOW:
            begin
                low_model[w.ch] = w.low;
                scale_model[w.ch] = w.scale;
            end
            default: ;
        endcase
    endtask

    function automatic logic [TDATA_W-1:0] pack_word(stream_word_t w);
        logic [TDATA_W-1:0] d;
        int                 c;
        d = '0;
        d[CH_LSB +: CH_W] = w.ch;
        d[INDEX_LSB +: LEVEL_W] = w.index;
        d[ENTRY_LSB +: COLOR_W] = w.entry;
        d[LOW_LSB +: SAMPLE_W] = w.low;
        d[SCALE_LSB +: SAMPLE_W] = w.scale;
        for (c = 0; c < SAMPLE_FIELDS; c++)
            d[SAMPLE_LSB + c*SAMPLE_W +: SAMPLE_W] = w.samples[c];
        return d;
    endfunction

    function automatic stream_word_t random_word();
        stream_word_t w;
        int           c;
        w.cmd = CMD_W'($urandom_range(0, 3));
        w.ch = CH_W'($urandom_range(0, 3));
        w.index = LEVEL_W'($urandom_range(0, 255));
        w.entry = COLOR_W'($urandom);
        w.low = $urandom;
        w.scale = $urandom;
        for (c = 0; c < SAMPLE_FIELDS; c++)
            w.samples[c] = $urandom;
        return w;
    endfunction

    function automatic logic [COLOR_W-1:0] random_tint();
        case ($urandom_range(0, 5))
            0, 1, 2: return COLOR_W'($urandom) & 24'h3F3F3F;
            3, 4:    return COLOR_W'($urandom);
            default: return ($urandom_range(0, 1) == 0) ? 24'h000000 : 24'hFFFFFF;
        endcase
    endfunction

    function automatic stream_word_t table_word(int ch, int index, logic [COLOR_W-1:0] entry);
        stream_word_t w;
        w = random_word();
        w.cmd = CMD_TABLE;
        w.ch = CH_W'(ch);
        w.index = LEVEL_W'(index);
        w.entry = entry;
        return w;
    endfunction

    function automatic stream_word_t window_word(int ch, logic [SAMPLE_W-1:0] low,
                                                 logic [SAMPLE_W-1:0] scale);
        stream_word_t w;
        w = random_word();
        w.cmd = CMD_WINDOW;
        w.ch = CH_W'(ch);
        w.low = low;
        w.scale = scale;
        return w;
    endfunction

    function automatic stream_word_t pixel_word(logic [SAMPLE_W-1:0] s0, logic [SAMPLE_W-1:0] s1,
                                                logic [SAMPLE_W-1:0] s2, logic [SAMPLE_W-1:0] s3);
        stream_word_t w;
        w = random_word();
        w.cmd = CMD_PIXEL;
        w.samples[0] = s0;
        w.samples[1] = s1;
        w.samples[2] = s2;
        w.samples[3] = s3;
        return w;
    endfunction

    // Random traffic: mostly pixels whose samples fall across the current windows.
    function automatic stream_word_t random_stimulus_word();
        stream_word_t w;
        logic [63:0]  width;
        logic [31:0]  span;
        int           c;
        int           pick;
        pick = $urandom_range(0, 99);
        w = random_word();
        if (pick < 66)
        begin
            w.cmd = CMD_PIXEL;
            for (c = 0; c < NUM_CH; c++)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    span = gen_width[c] + (gen_width[c] >> 2);
                    w.samples[c] = gen_low[c] + $urandom_range(0, span) - (gen_width[c] >> 3);
                end
                else if ($urandom_range(0, 3) == 0)
                    w.samples[c] = ($urandom_range(0, 1) == 0) ? 32'h7FFFFFFF : 32'h80000000;
            end
        end
        else if (pick < 84)
        begin
            w.cmd = CMD_TABLE;
            w.entry = random_tint();
        end
        else if (pick < 95)
        begin
            w.cmd = CMD_WINDOW;
            if ($urandom_range(0, 9) < 7)
            begin
                width = 64'($urandom_range(256, 32'h0100_0000));
                w.low = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
                w.scale = 32'(64'hFF_0000_0000 / width);
            end
            else if ($urandom_range(0, 3) == 0)
                w.scale = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFFFFFF;
        end
        else
            w.cmd = CMD_UNUSED;
        return w;
    endfunction

    task automatic note_word(stream_word_t w);
        logic [63:0] wide;
        if (w.cmd == CMD_TABLE)
            gen_written[int'(w.ch)*LEVELS + int'(w.index)] = 1'b1;
        else if (w.cmd == CMD_WINDOW)
        begin
            gen_low[w.ch] = w.low;
            gen_scale[w.ch] = w.scale;
            wide = (w.scale == '0) ? 64'h0010_0000 : 64'hFF_0000_0000 / {32'd0, w.scale};
            if (wide > 64'h4000_0000)
                wide = 64'h4000_0000;
            if (wide == 64'd0)
                wide = 64'd1;
            gen_width[w.ch] = wide[31:0];
        end
        pending_words.insert(pending_words.size(), w);
        queued_words = queued_words + 1;
    endtask

    // A pixel never reads an unloaded color entry on an enabled channel: any such entry
    // is written with a random tint just before the pixel.
    task automatic queue_word(stream_word_t w);
        logic [LEVEL_W-1:0] level;
        int                 c;
        if (w.cmd == CMD_PIXEL)
        begin
            for (c = 0; c < NUM_CH; c++)
            begin
                if (gen_enable[c])
                begin
                    level = window_level(w.samples[c], gen_low[c], gen_scale[c]);
                    if (!gen_written[c*LEVELS + int'(level)])
                        note_word(table_word(c, int'(level), random_tint()));
                end
            end
        end
        note_word(w);
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || s_tvalid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_enable(logic [ENABLE_W-1:0] mask);
        wait_idle();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= mask;
        enable_model = mask;
        gen_enable = mask;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Driver: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                apply_word(current_word);
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    current_word = pending_words.pop_front();
                    s_tdata <= pack_word(current_word);
                    s_tuser <= current_word.cmd;
                    s_tvalid <= 1'b1;
                    if (burst_left > 1)
                        burst_left = burst_left - 1;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted word and changes its stall pattern now and then.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("pixel %h arrived with no expected word", m_tdata);
                mismatch_count = mismatch_count + 1;
            end
            else
            begin
                wanted_pixel = expected_pixels.pop_front();
                if (m_tdata !== wanted_pixel)
                begin
                    $error("pixel mismatch: expected %h, actual %h", wanted_pixel, m_tdata);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
        if (ready_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_left = $urandom_range(32, 400);
        end
        else
            ready_left = ready_left - 1;
        case (ready_mode)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_LIGHT:  m_tready <= ($urandom_range(0, 9) >= 3);
            READY_HEAVY:  m_tready <= ($urandom_range(0, 9) >= 8);
            default:      m_tready <= (cycle_count[2:0] != 3'd0);
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [ENABLE_W-1:0] phase_masks [PHASE_COUNT];
        int                  c;
        int                  p;
        int                  n;
        for (c = 0; c < NUM_CH; c++)
        begin
            low_model[c] = '0;
            scale_model[c] = DEFAULT_SCALE;
            gen_low[c] = '0;
            gen_scale[c] = DEFAULT_SCALE;
            gen_width[c] = 32'h0001_0000;
        end
        enable_model = '0;
        gen_enable = '0;
        phase_masks[0] = 4'hF;
        phase_masks[1] = 4'h1;
        phase_masks[2] = 4'h6;
        phase_masks[3] = 4'h0;
        phase_masks[4] = 4'h8;
        phase_masks[5] = ENABLE_W'($urandom_range(1, 15));
        phase_masks[6] = 4'hF;
        phase_masks[7] = ENABLE_W'($urandom_range(0, 15));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // With no channel enabled every pixel is the fixed background color.
        queue_word(pixel_word($urandom, $urandom, $urandom, $urandom));
        queue_word(pixel_word(32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF));
        queue_word(table_word(0, 0, 24'h000000));
        queue_word(table_word(3, 255, 24'hFFFFFF));
        begin
            stream_word_t ignored;
            ignored = random_word();
            ignored.cmd = CMD_UNUSED;
            queue_word(ignored);
        end
        queue_word(pixel_word($urandom, $urandom, $urandom, $urandom));

        write_enable(4'hF);
        // Default window maps 0.0 .. 1.0 onto the full level range.
        queue_word(pixel_word(32'h0, 32'h0, 32'h0, 32'h0));
        queue_word(pixel_word(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        queue_word(pixel_word(32'h0000_8000, 32'h0000_4000, 32'h0000_C000, 32'h0000_0001));
        queue_word(pixel_word(32'h80000000, 32'hFFFF0000, 32'h7FFFFFFF, 32'h0000FFFF));
        queue_word(window_word(0, 32'h80000000, 32'hFFFFFFFF));
        queue_word(window_word(1, 32'h7FFFFFFF, 32'h0001_0000));
        queue_word(window_word(2, 32'h0, 32'h0));
        queue_word(window_word(3, 32'hFFFF_0000, 32'h0000_8000));
        queue_word(pixel_word(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        queue_word(pixel_word(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
        queue_word(table_word(2, 0, 24'hFFFFFF));
        queue_word(pixel_word(32'h0, 32'h7FFFFFFE, 32'h1234_5678, 32'h01FF_0000));
        queue_word(window_word(0, 32'h0, DEFAULT_SCALE));
        queue_word(pixel_word(32'h0000_8000, 32'h0, 32'h0, 32'h0));

        // Each phase queues at least PHASE_WORDS words, table loads included.
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            write_enable(phase_masks[p]);
            n = queued_words;
            while (queued_words - n < PHASE_WORDS)
                queue_word(random_stimulus_word());
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
